// ===== rtl/core/iatok_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iatok_pkg
// shared types and constants for the indent-aware tokenizer: event codes,
// event word layout and the per-byte event batch
// ---------------------------------------------------------------------------
package iatok_pkg;

    // event codes
    localparam logic [2:0] EV_INDENT  = 3'd0;
    localparam logic [2:0] EV_NEWLINE = 3'd1;
    localparam logic [2:0] EV_BYTE    = 3'd2;
    localparam logic [2:0] EV_END     = 3'd3;
    localparam logic [2:0] EV_QERR    = 3'd4;

    // at most this many events come from one input byte
    localparam int MAX_EVENTS = 4;

    // event queue geometry
    localparam int EVQ_DEPTH = 8;
    localparam int EVQ_AW    = 3;
    localparam int EVQ_CW    = 4;

    // packed output word width (27 payload bits, padded to bytes)
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [15:0] width;
        logic        last;
    } event_t;

    typedef struct packed {
        logic [2:0]            n;
        event_t [3:0]          ev;
    } batch_t;

    function automatic event_t mk_ev(input logic [2:0] kind, input logic [7:0] ch);
        event_t e;
        e.kind  = kind;
        e.ch    = ch;
        e.width = 16'd0;
        e.last  = 1'b0;
        return e;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/iatok_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iatok_scan
// scanner state and per-byte decode: turns one byte into a batch of up to
// four events and updates phase and indentation count on accept
// ---------------------------------------------------------------------------
module iatok_scan #(
    parameter int INDENT_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        text_byte,
    input  wire logic              end_of_input,
    output iatok_pkg::batch_t      batch
);

    localparam logic [3:0] PH_LINE  = 4'd0;
    localparam logic [3:0] PH_MID   = 4'd1;
    localparam logic [3:0] PH_WORD  = 4'd2;
    localparam logic [3:0] PH_COLON = 4'd3;
    localparam logic [3:0] PH_STR   = 4'd4;
    localparam logic [3:0] PH_ESC   = 4'd5;
    localparam logic [3:0] PH_COMMA = 4'd6;
    localparam logic [3:0] PH_QCHK  = 4'd7;
    localparam logic [3:0] PH_CMT   = 4'd8;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;

    typedef struct packed {
        logic [1:0]        n;
        iatok_pkg::event_t e0;
        iatok_pkg::event_t e1;
        logic [3:0]        phase;
        logic              line_reset;
    } btok_t;

    logic [3:0]             phase_reg, phase_next;
    logic [INDENT_BITS-1:0] cnt_reg, cnt_next;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_QUOTE) || (c == CH_BTICK) || (c == CH_AT);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return is_ws(c) || is_quote(c) || (c == CH_LPAR) || (c == CH_RPAR) ||
               (c == CH_HASH) || (c == CH_DQUOTE) || (c == CH_COMMA);
    endfunction

    // handling of a byte that arrives between tokens
    function automatic btok_t between(input logic [7:0] c);
        btok_t r;
        r.n          = 2'd0;
        r.e0         = iatok_pkg::mk_ev(iatok_pkg::EV_BYTE, c);
        r.e1         = iatok_pkg::mk_ev(iatok_pkg::EV_END, 8'd0);
        r.phase      = PH_MID;
        r.line_reset = 1'b0;
        if (c == CH_LF) begin
            r.n          = 2'd1;
            r.e0         = iatok_pkg::mk_ev(iatok_pkg::EV_NEWLINE, 8'd0);
            r.phase      = PH_LINE;
            r.line_reset = 1'b1;
        end
        else if (is_ws(c)) begin
            r.phase = PH_MID;
        end
        else if (c == CH_HASH) begin
            r.phase = PH_CMT;
        end
        else if (c == CH_DQUOTE) begin
            r.n     = 2'd1;
            r.phase = PH_STR;
        end
        else if ((c == CH_LPAR) || (c == CH_RPAR)) begin
            r.n     = 2'd2;
            r.phase = PH_MID;
        end
        else if (c == CH_COMMA) begin
            r.n     = 2'd1;
            r.phase = PH_COMMA;
        end
        else if (is_quote(c)) begin
            r.n     = 2'd2;
            r.phase = PH_QCHK;
        end
        else if (c == CH_COLON) begin
            r.phase = PH_COLON;
        end
        else begin
            r.n     = 2'd1;
            r.phase = PH_WORD;
        end
        return r;
    endfunction

    btok_t                   bt;
    logic [INDENT_BITS:0]    sum_sp, sum_tab;
    logic [INDENT_BITS+15:0] cnt_ext;

    assign bt      = between(text_byte);
    assign sum_sp  = {1'b0, cnt_reg} + {{INDENT_BITS{1'b0}}, 1'b1};
    assign sum_tab = {1'b0, cnt_reg} + {{(INDENT_BITS-1){1'b0}}, 2'd2};
    assign cnt_ext = {16'd0, cnt_reg};

    always_comb
    begin
        logic [1:0]             pre_n;
        iatok_pkg::event_t      p0, p1;
        logic                   use_bt;
        logic [2:0]             n;
        iatok_pkg::batch_t      b;

        pre_n      = 2'd0;
        p0         = iatok_pkg::mk_ev(iatok_pkg::EV_BYTE, text_byte);
        p1         = iatok_pkg::mk_ev(iatok_pkg::EV_BYTE, text_byte);
        use_bt     = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;

        if (end_of_input) begin
            // flush: open word, string or comma gets its end
            if ((phase_reg == PH_WORD) || (phase_reg == PH_STR) ||
                (phase_reg == PH_ESC) || (phase_reg == PH_COMMA))
            begin
                pre_n = 2'd1;
                p0    = iatok_pkg::mk_ev(iatok_pkg::EV_END, 8'd0);
            end
            phase_next = PH_LINE;
            cnt_next   = '0;
        end
        else begin
            unique case (phase_reg)
                PH_LINE:
                begin
                    if (text_byte == CH_LF) begin
                        pre_n    = 2'd1;
                        p0       = iatok_pkg::mk_ev(iatok_pkg::EV_NEWLINE, 8'd0);
                        cnt_next = '0;
                    end
                    else if (text_byte == CH_SP) begin
                        cnt_next = sum_sp[INDENT_BITS] ? '1 : sum_sp[INDENT_BITS-1:0];
                    end
                    else if (text_byte == CH_TAB) begin
                        cnt_next = sum_tab[INDENT_BITS] ? '1 : sum_tab[INDENT_BITS-1:0];
                    end
                    else if (is_ws(text_byte)) begin
                        cnt_next = cnt_reg;
                    end
                    else if (text_byte == CH_HASH) begin
                        phase_next = PH_CMT;
                    end
                    else begin
                        pre_n    = 2'd1;
                        p0       = iatok_pkg::mk_ev(iatok_pkg::EV_INDENT, 8'd0);
                        p0.width = cnt_ext[15:0];
                        use_bt   = 1'b1;
                    end
                end
                PH_WORD:
                begin
                    pre_n = 2'd1;
                    if (is_delim(text_byte)) begin
                        p0     = iatok_pkg::mk_ev(iatok_pkg::EV_END, 8'd0);
                        use_bt = 1'b1;
                    end
                end
                PH_COLON:
                begin
                    if (is_delim(text_byte)) begin
                        // lone colon is dropped
                        use_bt = 1'b1;
                    end
                    else begin
                        pre_n      = 2'd2;
                        p0         = iatok_pkg::mk_ev(iatok_pkg::EV_BYTE, CH_COLON);
                        phase_next = PH_WORD;
                    end
                end
                PH_STR:
                begin
                    pre_n = 2'd1;
                    if (text_byte == CH_BSLASH) begin
                        phase_next = PH_ESC;
                    end
                    else if (text_byte == CH_DQUOTE) begin
                        pre_n      = 2'd2;
                        p1         = iatok_pkg::mk_ev(iatok_pkg::EV_END, 8'd0);
                        phase_next = PH_MID;
                    end
                end
                PH_ESC:
                begin
                    pre_n      = 2'd1;
                    phase_next = PH_STR;
                end
                PH_COMMA:
                begin
                    if (text_byte == CH_AT) begin
                        pre_n      = 2'd2;
                        p1         = iatok_pkg::mk_ev(iatok_pkg::EV_END, 8'd0);
                        phase_next = PH_MID;
                    end
                    else begin
                        pre_n  = 2'd1;
                        p0     = iatok_pkg::mk_ev(iatok_pkg::EV_END, 8'd0);
                        use_bt = 1'b1;
                    end
                end
                PH_QCHK:
                begin
                    if (is_ws(text_byte) || (text_byte == CH_RPAR)) begin
                        pre_n = 2'd1;
                        p0    = iatok_pkg::mk_ev(iatok_pkg::EV_QERR, 8'd0);
                    end
                    use_bt = 1'b1;
                end
                PH_CMT:
                begin
                    if (text_byte == CH_LF) begin
                        pre_n      = 2'd1;
                        p0         = iatok_pkg::mk_ev(iatok_pkg::EV_NEWLINE, 8'd0);
                        phase_next = PH_LINE;
                        cnt_next   = '0;
                    end
                end
                default:
                begin
                    use_bt = 1'b1;
                end
            endcase

            if (use_bt) begin
                phase_next = bt.phase;
                if (bt.line_reset) begin
                    cnt_next = '0;
                end
            end
        end

        // assemble prefix events followed by between-token events
        b.ev = {4{iatok_pkg::mk_ev(iatok_pkg::EV_END, 8'd0)}};
        n    = 3'd0;
        if (pre_n >= 2'd1) begin
            b.ev[n[1:0]] = p0;
            n            = n + 3'd1;
        end
        if (pre_n >= 2'd2) begin
            b.ev[n[1:0]] = p1;
            n            = n + 3'd1;
        end
        if (use_bt && (bt.n >= 2'd1)) begin
            b.ev[n[1:0]] = bt.e0;
            n            = n + 3'd1;
        end
        if (use_bt && (bt.n >= 2'd2)) begin
            b.ev[n[1:0]] = bt.e1;
            n            = n + 3'd1;
        end
        if (n != 3'd0) begin
            b.ev[2'(n - 3'd1)].last = 1'b1;
        end
        b.n   = n;
        batch = b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_LINE;
            cnt_reg   <= '0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/iatok_evq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// iatok_evq
// event queue: takes a batch of up to four events per cycle and hands out
// one event word per cycle, while m_tready is high, on the output stream
// ---------------------------------------------------------------------------
module iatok_evq (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire iatok_pkg::batch_t                   batch,
    output logic                                     room,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [iatok_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                     m_tlast
);

    iatok_pkg::event_t                  q_reg [iatok_pkg::EVQ_DEPTH];
    logic [iatok_pkg::EVQ_AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [iatok_pkg::EVQ_CW-1:0]       count_reg, count_next;
    logic                               pop;
    iatok_pkg::event_t                  head;

    // room for a full batch, from registered count only
    assign room     = (count_reg <= 4'(iatok_pkg::EVQ_DEPTH - iatok_pkg::MAX_EVENTS));
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign head     = q_reg[rd_ptr_reg];
    assign m_tdata  = {5'd0, head.width, head.ch, head.kind};
    assign m_tlast  = head.last;

    always_comb
    begin
        count_next = count_reg;
        if (push) begin
            count_next = count_next + {1'b0, batch.n};
        end
        if (pop) begin
            count_next = count_next - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < iatok_pkg::MAX_EVENTS; k++) begin
            if (push && (3'(k) < batch.n)) begin
                q_reg[wr_ptr_reg + 3'(k)] <= batch.ev[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + batch.n;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 3'd1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/indent_aware_lisp_tokenizer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// indent_aware_lisp_tokenizer_unit
// byte-stream tokenizer for an indentation-sensitive parenthesized language;
// emits indent, newline, token byte, token end and quote error events
// ---------------------------------------------------------------------------
//
// channel   dir  tdata                              tuser  tlast
// s_axis    in   [7:0] text_byte                    -      end_of_input
// m_axis    out  [2:0] event_kind, [10:3]           -      last_event
//                token_char, [26:11] indent_width
//
// one byte is taken per cycle while the queue has room; its events (zero to
// four) go into an eight word queue with a registered count and leave one
// word per cycle while m_tready is high. the input is held while fewer than
// four queue slots are free, so a stalled output stalls the input only
// then; when bytes average more than one event, the sustained input rate
// is set by the output drain. reset puts the scanner at start of line with
// a zero indentation count and empties the queue.
//
module indent_aware_lisp_tokenizer_unit #(
    parameter int INDENT_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input byte stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] text_byte
    input  wire logic                            s_tlast,   // end_of_input
    // event word stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] event_kind, [10:3] token_char, [26:11] indent_width, [31:27] zero
    output logic [iatok_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                 m_tlast    // last_event
);

    logic              room;
    logic              accept;
    iatok_pkg::batch_t batch;

    // take a byte whenever the queue can hold a worst-case batch
    assign s_tready = room;
    assign accept   = s_tvalid && room;

    // phase / indentation state and byte decode
    iatok_scan #(
        .INDENT_BITS (INDENT_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .text_byte    (s_tdata),
        .end_of_input (s_tlast),
        .batch        (batch)
    );

    // event queue doubles as the output register
    iatok_evq u_evq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .batch    (batch),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
